### rtl/gbs_pkg.sv
// ----------------------------------------------------------------------------
// gbs_pkg
// Shared types, constants and helpers for the greedy box suppression unit.
// ----------------------------------------------------------------------------
package gbs_pkg;

  localparam int MAX_BOXES_DEF = 64;
  localparam int COORD_W       = 14;
  localparam int SCORE_W       = 16;
  localparam int CLASS_W       = 8;
  localparam int EXT_W         = 15;
  // full 14-bit corners give extents up to 16399, so an area needs 29 bits
  localparam int AREA_W        = 29;
  localparam int SUM_W         = 30;
  localparam int THR_W         = 17;
  localparam int LHS_W         = AREA_W + 16;
  localparam int RHS_W         = THR_W + SUM_W;
  localparam logic [THR_W-1:0] THR_RESET = 17'd39322;
  localparam logic [EXT_W-1:0] PIXEL_ONE = 15'd16;

  // One box as it arrives, left corner in the lowest bits
  typedef struct packed {
    logic [CLASS_W-1:0] class_tag;
    logic [SCORE_W-1:0] confidence;
    logic [COORD_W-1:0] bottom_edge;
    logic [COORD_W-1:0] right_edge;
    logic [COORD_W-1:0] top_edge;
    logic [COORD_W-1:0] left_edge;
  } box_t;

  localparam int BOX_W = $bits(box_t);

  // Ranked box with its area
  typedef struct packed {
    logic [AREA_W-1:0] area;
    box_t              box;
  } rbox_t;

  localparam int RBOX_W = $bits(rbox_t);

  // Inclusive-pixel extent, zero when inverted
  function automatic logic [EXT_W-1:0] extent(input logic [COORD_W-1:0] lo,
                                              input logic [COORD_W-1:0] hi);
    logic [EXT_W-1:0] top;
    top = {1'b0, hi} + PIXEL_ONE;
    return (top > {1'b0, lo}) ? top - {1'b0, lo} : '0;
  endfunction

endpackage

### rtl/gbs_ram.sv
// ----------------------------------------------------------------------------
// gbs_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module gbs_ram #(
  parameter int W = 8,
  parameter int D = 64
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/gbs_iou.sv
// ----------------------------------------------------------------------------
// gbs_iou
// Pipelined overlap test: flags a lower box whose IoU with the anchor box
// reaches the threshold, without division.
// ----------------------------------------------------------------------------
module gbs_iou
  import gbs_pkg::*;
#(
  parameter int AW = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  rbox_t            anchor,
  input  rbox_t            cand,
  input  logic             cand_valid,
  input  logic [AW-1:0]    cand_idx,
  input  logic [THR_W-1:0] threshold,
  output logic             kill_valid,
  output logic             kill,
  output logic [AW-1:0]    kill_idx,
  output logic             busy
);

  logic [EXT_W-1:0]  iw, ih;
  logic [SUM_W-1:0]  sum1, sum2;
  logic [AREA_W-1:0] inter2;
  logic [SUM_W-1:0]  uni3;
  logic [LHS_W-1:0]  lhs3, lhs4;
  logic [RHS_W-1:0]  rhs4;
  logic              nz4;
  logic [AW-1:0]     idx1, idx2, idx3, idx4;
  logic              v1, v2, v3, v4;
  logic [COORD_W-1:0] lo_x, lo_y, hi_x, hi_y;

  // intersection corners
  always_comb begin
    lo_x = (anchor.box.left_edge > cand.box.left_edge) ? anchor.box.left_edge
                                                       : cand.box.left_edge;
    lo_y = (anchor.box.top_edge > cand.box.top_edge) ? anchor.box.top_edge
                                                     : cand.box.top_edge;
    hi_x = (anchor.box.right_edge < cand.box.right_edge) ? anchor.box.right_edge
                                                         : cand.box.right_edge;
    hi_y = (anchor.box.bottom_edge < cand.box.bottom_edge) ? anchor.box.bottom_edge
                                                           : cand.box.bottom_edge;
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      kill_valid <= 1'b0;
    end else begin
      v1 <= cand_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      kill_valid <= v4;
    end
  end

  // datapath: extents, product, union, threshold product, compare
  always_ff @(posedge clk) begin
    iw     <= extent(lo_x, hi_x);
    ih     <= extent(lo_y, hi_y);
    sum1   <= {1'b0, anchor.area} + {1'b0, cand.area};
    idx1   <= cand_idx;
    inter2 <= AREA_W'(iw * ih);
    sum2   <= sum1;
    idx2   <= idx1;
    uni3   <= sum2 - {1'b0, inter2};
    lhs3   <= {inter2, 16'd0};
    idx3   <= idx2;
    rhs4   <= RHS_W'(threshold * uni3);
    lhs4   <= lhs3;
    nz4    <= (uni3 != '0);
    idx4   <= idx3;
    kill     <= nz4 && ({2'b0, lhs4} >= rhs4);
    kill_idx <= idx4;
  end

  assign busy = v1 | v2 | v3 | v4 | kill_valid;

endmodule

### rtl/greedy_box_suppression_unit.sv
// ----------------------------------------------------------------------------
// greedy_box_suppression_unit
// Greedy class-agnostic non-maximum suppression over one set of boxes.
// ----------------------------------------------------------------------------
// Boxes stream in one per cycle until the item with tlast; a set holds at most
// MAX_BOXES boxes and later ones are dropped and flagged in tuser. The set is
// then ranked by descending score (ties keep arrival order) by counting over
// the score memory, then suppressed pairwise through a five-stage overlap
// pipeline fed from the ranked memory, and survivors leave in rank order,
// each held on the output until it is taken. Each memory has a single read
// port. No input is taken until the last survivor of a set has left.
module greedy_box_suppression_unit
  import gbs_pkg::*;
#(
  parameter int MAX_BOXES = MAX_BOXES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [THR_W-1:0] cfg_wr_data,    // iou_threshold
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // left_edge, top_edge, right_edge, bottom_edge, confidence, class_tag
  input  logic [79:0]      s_axis_tdata,
  input  logic             s_axis_tlast,   // set_end
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // kept_left, kept_top, kept_right, kept_bottom, kept_score, kept_class
  output logic [79:0]      m_axis_tdata,
  output logic             m_axis_tlast,   // final_box
  output logic             m_axis_tuser    // capacity_exceeded
);

  localparam int AW = $clog2(MAX_BOXES);
  localparam int CW = $clog2(MAX_BOXES + 1);
  localparam logic [CW-1:0] CAP = CW'(MAX_BOXES);

  typedef enum logic [3:0] {
    LOAD, R_RD, R_LAT, R_SCAN, S_RD, S_LAT, S_SCAN, E_RD, E_LAT, E_OUT
  } state_t;

  state_t st;
  logic [THR_W-1:0] thr;
  logic [CW-1:0]    n, ri, rj, si, sj;
  logic [AW-1:0]    cnt, sjd, last, rdi;
  logic             ovf, sv, rdv;
  logic [MAX_BOXES-1:0] alive;
  box_t             bi;
  logic [AREA_W-1:0] area_r;
  rbox_t            anchor;

  box_t             in_box, box_rdata;
  logic [SCORE_W-1:0] score_rdata;
  rbox_t            rk_rdata;
  logic             in_acc, store_we, rk_we;
  logic [AW-1:0]    rk_raddr;
  logic             kv, kk, ib;
  logic [AW-1:0]    kidx;
  logic             beats;

  assign in_box = box_t'(s_axis_tdata);
  assign s_axis_tready = (st == LOAD);
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign store_we = in_acc && (n < CAP);
  assign rk_we = (st == R_SCAN) && (rj == n) && !sv;
  assign rk_raddr = (st == S_SCAN) ? sj[AW-1:0] : si[AW-1:0];
  assign beats = (score_rdata > bi.confidence) ||
                 ((score_rdata == bi.confidence) && (sjd < ri[AW-1:0]));

  gbs_ram #(.W(BOX_W), .D(MAX_BOXES)) u_box_ram (
    .clk(clk), .we(store_we), .waddr(n[AW-1:0]), .wdata(in_box),
    .raddr(ri[AW-1:0]), .rdata(box_rdata)
  );

  gbs_ram #(.W(SCORE_W), .D(MAX_BOXES)) u_score_ram (
    .clk(clk), .we(store_we), .waddr(n[AW-1:0]), .wdata(in_box.confidence),
    .raddr(rj[AW-1:0]), .rdata(score_rdata)
  );

  gbs_ram #(.W(RBOX_W), .D(MAX_BOXES)) u_rank_ram (
    .clk(clk), .we(rk_we), .waddr(cnt), .wdata({area_r, bi}),
    .raddr(rk_raddr), .rdata(rk_rdata)
  );

  gbs_iou #(.AW(AW)) u_iou (
    .clk(clk), .rst(rst), .anchor(anchor), .cand(rk_rdata), .cand_valid(rdv),
    .cand_idx(rdi), .threshold(thr), .kill_valid(kv), .kill(kk),
    .kill_idx(kidx), .busy(ib)
  );

  // threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_RESET;
    end else if (cfg_wr_en) begin
      thr <= cfg_wr_data;
    end
  end

  // sequencer: load, rank, suppress, emit
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= LOAD;
      n <= '0;
      ovf <= 1'b0;
      alive <= '0;
      sv <= 1'b0;
      rdv <= 1'b0;
      m_axis_tvalid <= 1'b0;
      ri <= '0;
      rj <= '0;
      si <= '0;
      sj <= '0;
      cnt <= '0;
      last <= '0;
    end else begin
      sv <= 1'b0;
      rdv <= 1'b0;
      if (kv && kk) begin
        alive[kidx] <= 1'b0;
      end
      unique case (st)
        LOAD: begin
          if (in_acc) begin
            if (n < CAP) begin
              n <= n + 1'b1;
            end else begin
              ovf <= 1'b1;
            end
            if (s_axis_tlast) begin
              ri <= '0;
              st <= R_RD;
            end
          end
        end
        R_RD: st <= R_LAT;
        R_LAT: begin
          bi <= box_rdata;
          rj <= '0;
          cnt <= '0;
          st <= R_SCAN;
        end
        R_SCAN: begin
          area_r <= AREA_W'(extent(bi.left_edge, bi.right_edge) *
                            extent(bi.top_edge, bi.bottom_edge));
          if (rj < n) begin
            sv <= 1'b1;
            sjd <= rj[AW-1:0];
            rj <= rj + 1'b1;
          end
          if (sv && beats) begin
            cnt <= cnt + 1'b1;
          end
          if (rj == n && !sv) begin
            ri <= ri + 1'b1;
            if (ri + 1'b1 == n) begin
              for (int k = 0; k < MAX_BOXES; k++) begin
                alive[k] <= (CW'(k) < n);
              end
              si <= '0;
              st <= S_RD;
            end else begin
              st <= R_RD;
            end
          end
        end
        S_RD: st <= S_LAT;
        S_LAT: begin
          anchor <= rk_rdata;
          if (alive[si[AW-1:0]]) begin
            last <= si[AW-1:0];
            sj <= si + 1'b1;
            st <= S_SCAN;
          end else if (si + 1'b1 == n) begin
            si <= '0;
            st <= E_RD;
          end else begin
            si <= si + 1'b1;
            st <= S_RD;
          end
        end
        S_SCAN: begin
          if (sj < n) begin
            rdv <= 1'b1;
            rdi <= sj[AW-1:0];
            sj <= sj + 1'b1;
          end else if (!rdv && !ib) begin
            if (si + 1'b1 == n) begin
              si <= '0;
              st <= E_RD;
            end else begin
              si <= si + 1'b1;
              st <= S_RD;
            end
          end
        end
        E_RD: begin
          if (si == n) begin
            n <= '0;
            ovf <= 1'b0;
            alive <= '0;
            st <= LOAD;
          end else if (alive[si[AW-1:0]]) begin
            st <= E_LAT;
          end else begin
            si <= si + 1'b1;
          end
        end
        E_LAT: begin
          m_axis_tdata <= rk_rdata.box;
          m_axis_tlast <= (si[AW-1:0] == last);
          m_axis_tuser <= ovf;
          m_axis_tvalid <= 1'b1;
          st <= E_OUT;
        end
        E_OUT: begin
          if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
            si <= si + 1'b1;
            st <= E_RD;
          end
        end
        default: st <= LOAD;
      endcase
    end
  end

`ifndef SYNTHESIS
  // input and output sides never active together
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !m_axis_tvalid)
    else $error("input ready while a result is pending");

  // fill count never exceeds capacity
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    n <= CAP)
    else $error("box count beyond capacity");

  // alive marks are clear while loading
  a_alive_clear: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> (alive == '0))
    else $error("alive marks left over from previous set");

  // a result leaves only with a survivor index in range
  a_emit_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (si < n))
    else $error("result index outside the set");
`endif

endmodule
